// ===== rtl/sdct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sdct_pkg;

  // Counter geometry
  localparam int COUNT_WIDTH = 24;
  localparam int SLOW_DIVIDE = 8;
  localparam int PRE_W       = $clog2(SLOW_DIVIDE);

  // Field widths
  localparam int REQ_W     = 2;
  localparam int SEL_W     = 2;
  localparam int DATA_W    = 32;
  localparam int ELAPSED_W = 24;

  // Stream packing
  localparam int IN_TDATA_W  = DATA_W;                // write_data
  localparam int IN_TUSER_W  = REQ_W + SEL_W;         // req_type, reg_sel
  localparam int OUT_USED_W  = DATA_W + 1 + ELAPSED_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // CTRL bit positions
  localparam int CTRL_EN_BIT   = 0;
  localparam int CTRL_INT_BIT  = 1;
  localparam int CTRL_SRC_BIT  = 2;
  localparam int CTRL_FLAG_BIT = 16;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd2;

  // Register selects
  localparam logic [SEL_W-1:0] REG_CTRL = 2'd0;
  localparam logic [SEL_W-1:0] REG_LOAD = 2'd1;
  localparam logic [SEL_W-1:0] REG_VAL  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [SEL_W-1:0]  reg_sel;
    logic [DATA_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [ELAPSED_W-1:0] elapsed;
    logic                 irq;
    logic [DATA_W-1:0]    read_data;
  } result_t;

  // Handshake between the input stage and the core
  typedef struct packed {
    logic valid;
    item_t item;
  } item_chan_t;

endpackage

`default_nettype wire

// ===== rtl/sdct_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sdct_in_reg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  sdct_pkg::item_t              in_item_i,
  output sdct_pkg::item_chan_t         out_chan_o,
  input  logic                         out_ready_i
);
  import sdct_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  take;

  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_item_i;
    end
  end

  assign out_chan_o.valid = valid_q;
  assign out_chan_o.item  = item_q;

endmodule

`default_nettype wire

// ===== rtl/sdct_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sdct_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_wr_i,
  input  logic                   cfg_single_shot_i,
  input  sdct_pkg::item_chan_t   in_chan_i,
  output logic                   in_ready_o,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output sdct_pkg::result_t      res_o
);
  import sdct_pkg::*;

  logic                   single_shot_q;
  logic                   run_q, run_d;
  logic                   int_en_q, int_en_d;
  logic                   fast_q, fast_d;
  logic                   flag_q, flag_d;
  logic [COUNT_WIDTH-1:0] reload_q, reload_d;
  logic [COUNT_WIDTH-1:0] cur_q, cur_d;
  logic [PRE_W-1:0]       pre_q, pre_d;
  logic [PRE_W:0]         pre_inc;
  logic [COUNT_WIDTH-1:0] dec;
  logic [COUNT_WIDTH-1:0] diff;
  logic                   counts;
  logic                   fired;
  logic [DATA_W-1:0]      rd;
  logic                   res_valid_q, res_valid_d;
  result_t                res_q;
  logic                   adv;
  item_t                  it;

  assign it         = in_chan_i.item;
  assign in_ready_o = !res_valid_q || res_ready_i;
  assign adv        = in_chan_i.valid && in_ready_o;

  always_comb begin
    run_d    = run_q;
    int_en_d = int_en_q;
    fast_d   = fast_q;
    flag_d   = flag_q;
    reload_d = reload_q;
    cur_d    = cur_q;
    pre_d    = pre_q;
    pre_inc  = {1'b0, pre_q} + (PRE_W+1)'(1);
    dec      = cur_q - COUNT_WIDTH'(1);
    counts   = 1'b0;
    fired    = 1'b0;
    rd       = '0;

    case (it.req_type)
      REQ_TICK: begin
        if (run_q) begin
          if (fast_q) begin
            counts = 1'b1;
          end else if (pre_inc >= (PRE_W+1)'(SLOW_DIVIDE)) begin
            counts = 1'b1;
            pre_d  = '0;
          end else begin
            pre_d = pre_inc[PRE_W-1:0];
          end
          if (counts) begin
            if (cur_q == '0) begin
              cur_d = reload_q;
            end else begin
              cur_d = dec;
              if (dec == '0) begin
                flag_d = 1'b1;
                fired  = int_en_q;
                if (single_shot_q) begin
                  run_d    = 1'b0;
                  reload_d = '0;
                  cur_d    = '0;
                end
              end
            end
          end
        end
      end
      REQ_READ: begin
        case (it.reg_sel)
          REG_CTRL: begin
            rd[CTRL_EN_BIT]   = run_q;
            rd[CTRL_INT_BIT]  = int_en_q;
            rd[CTRL_SRC_BIT]  = fast_q;
            rd[CTRL_FLAG_BIT] = flag_q;
            flag_d            = 1'b0;  // clear on read
          end
          REG_LOAD: rd = DATA_W'(reload_q);
          REG_VAL:  rd = DATA_W'(cur_q);
          default:  rd = '0;
        endcase
      end
      REQ_WRITE: begin
        case (it.reg_sel)
          REG_CTRL: begin
            run_d    = it.write_data[CTRL_EN_BIT];
            int_en_d = it.write_data[CTRL_INT_BIT];
            fast_d   = it.write_data[CTRL_SRC_BIT];
          end
          REG_LOAD: reload_d = it.write_data[COUNT_WIDTH-1:0];
          REG_VAL: begin
            cur_d  = '0;
            flag_d = 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    diff = reload_d - cur_d;
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (adv) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      single_shot_q <= 1'b0;
      run_q         <= 1'b0;
      int_en_q      <= 1'b0;
      fast_q        <= 1'b0;
      flag_q        <= 1'b0;
      reload_q      <= '0;
      cur_q         <= '0;
      pre_q         <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (cfg_wr_i) begin
        single_shot_q <= cfg_single_shot_i;
      end
      if (adv) begin
        run_q    <= run_d;
        int_en_q <= int_en_d;
        fast_q   <= fast_d;
        flag_q   <= flag_d;
        reload_q <= reload_d;
        cur_q    <= cur_d;
        pre_q    <= pre_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q.read_data <= rd;
      res_q.irq       <= fired;
      res_q.elapsed   <= ELAPSED_W'(diff);
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== rtl/systick_down_counter_timer_top.sv =====
// Channel | Dir | Handshake                        | Word layout (low bit up)
// s_axis  | in  | s_axis_tvalid_i / s_axis_tready_o | tdata: write_data[31:0]
//         |     |                                  | tuser: req_type[1:0], reg_sel[3:2]
// m_axis  | out | m_axis_tvalid_o / m_axis_tready_i | tdata: read_data[31:0], irq[32],
//         |     |                                  |        elapsed[56:33], zeros[63:57]
// cfg     | in  | cfg_valid_i / cfg_ready_o        | cfg_data_i: single_shot
//
// One word per cycle sustained while m_axis is not stalled. A word accepted on s_axis
// passes one input register, then the counter update and result register, to m_axis.
// Reset (rst_ni low, async) clears the counter, CTRL, LOAD, VAL, prescaler and
// single_shot. A stalled m_axis fills the input register, then drops s_axis_tready_o.
// cfg_ready_o is always high.
`timescale 1ns / 1ps
`default_nettype none

module systick_down_counter_timer_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // slave stream: tdata = write_data; tuser = req_type, reg_sel
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [sdct_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  input  logic [sdct_pkg::IN_TUSER_W-1:0]      s_axis_tuser_i,
  // master stream: tdata = read_data, irq, elapsed, zero fill
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [sdct_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  // configuration: single_shot
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic                                 cfg_data_i
);
  import sdct_pkg::*;

  item_t      in_item;
  item_chan_t core_chan;
  logic       core_ready;
  result_t    res;

  assign in_item.req_type   = s_axis_tuser_i[REQ_W-1:0];
  assign in_item.reg_sel    = s_axis_tuser_i[REQ_W +: SEL_W];
  assign in_item.write_data = s_axis_tdata_i;

  assign cfg_ready_o = 1'b1;

  sdct_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_item_i   (in_item),
    .out_chan_o  (core_chan),
    .out_ready_i (core_ready)
  );

  sdct_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_wr_i          (cfg_valid_i && cfg_ready_o),
    .cfg_single_shot_i (cfg_data_i),
    .in_chan_i         (core_chan),
    .in_ready_o        (core_ready),
    .res_valid_o       (m_axis_tvalid_o),
    .res_ready_i       (m_axis_tready_i),
    .res_o             (res)
  );

  assign m_axis_tdata_o = OUT_TDATA_W'(res);

endmodule

`default_nettype wire

// ===== rtl/sdct_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sdct_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [sdct_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);
  import sdct_pkg::*;

  logic [DATA_W-1:0] rd;
  logic              irq;

  assign rd  = m_axis_tdata_o[DATA_W-1:0];
  assign irq = m_axis_tdata_o[DATA_W];

  // stalled output word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output word changed under stall");

  // input only backs up when the output is full and stalled
  a_bp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output backpressure");

  // irq comes only from ticks, which return no read data
  a_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && irq |-> rd == '0)
    else $error("irq with nonzero read data");

  // read data never exceeds the counter width
  a_rdw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (64'(rd) >> COUNT_WIDTH) == 64'd0)
    else $error("read data wider than counter");

endmodule

bind systick_down_counter_timer_top sdct_checker u_sdct_checker (.*);

`default_nettype wire
